[hw/rtl/kaf_pkg.sv]
// ----------------------------------------------------------------------------
// kaf_pkg
// shared constants, register indexes and state types of the angle kalman filter
// ----------------------------------------------------------------------------
`default_nettype none

package kaf_pkg;

  localparam int KAF_WORD_BITS = 48;
  localparam int KAF_FRAC_BITS = 32;
  localparam int FIELD_BITS    = 48;
  localparam int NOISE_BITS    = 32;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [NOISE_BITS-1:0] ANGLE_NOISE_RST = 32'd128849019;
  localparam logic [NOISE_BITS-1:0] BIAS_NOISE_RST  = 32'd386547;
  localparam logic [NOISE_BITS-1:0] MEAS_NOISE_RST  = 32'd429497;

  localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEAS_NOISE  = 2'd2;

  // phase of the serial multiplier and divider
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_RND,
    PH_SAT
  } kaf_phase_t;

  // sequencer steps of one filter update
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_ANG,
    ST_M_AA,
    ST_M_AB,
    ST_M_BB,
    ST_GAIN,
    ST_D_K0,
    ST_D_K1,
    ST_M_CAA,
    ST_M_CAB,
    ST_M_CBA,
    ST_M_CBB,
    ST_M_CANG,
    ST_M_CBIAS,
    ST_OUT
  } kaf_state_t;

endpackage

`default_nettype wire

[hw/rtl/kaf_mul.sv]
// ----------------------------------------------------------------------------
// kaf_mul
// bit-serial signed multiplier with round-half-away shift and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module kaf_mul #(
  parameter int WORD_BITS = kaf_pkg::KAF_WORD_BITS,
  parameter int FRAC_BITS = kaf_pkg::KAF_FRAC_BITS,
  parameter int OP_BITS   = kaf_pkg::KAF_WORD_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic signed [OP_BITS-1:0]   op_a,
  input  wire logic signed [OP_BITS-1:0]   op_b,
  input  wire logic                        frac_shift,
  output logic                             done,
  output logic signed [WORD_BITS-1:0]      result
);

  localparam int PW = 2 * OP_BITS;
  localparam int CW = $clog2(OP_BITS);
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [PW:0] HALF_F = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0] HALF_Q = (PW+1)'(1) << 31;

  kaf_pkg::kaf_phase_t phase_r, phase_nxt;
  logic [CW-1:0]      cnt_r;
  logic [OP_BITS-1:0] ma_r;
  logic [PW-1:0]      prod_r;
  logic [PW:0]        rnd_r;
  logic               neg_r;
  logic               frac_r;

  logic [OP_BITS-1:0] ma;
  logic [OP_BITS-1:0] mb;
  logic [OP_BITS:0]   sum;
  logic [PW:0]        wide;
  logic               big;
  logic [WORD_BITS-1:0] mag;

  assign ma   = op_a[OP_BITS-1] ? OP_BITS'(-op_a) : OP_BITS'(op_a);
  assign mb   = op_b[OP_BITS-1] ? OP_BITS'(-op_b) : OP_BITS'(op_b);
  assign sum  = {1'b0, prod_r[PW-1:OP_BITS]} + {1'b0, ma_r};
  assign wide = {1'b0, prod_r};
  assign big  = |rnd_r[PW:WORD_BITS-1];
  assign mag  = rnd_r[WORD_BITS-1:0];

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      kaf_pkg::PH_IDLE: if (start) phase_nxt = kaf_pkg::PH_RUN;
      kaf_pkg::PH_RUN:  if (cnt_r == CW'(OP_BITS - 1)) phase_nxt = kaf_pkg::PH_RND;
      kaf_pkg::PH_RND:  phase_nxt = kaf_pkg::PH_SAT;
      kaf_pkg::PH_SAT:  phase_nxt = kaf_pkg::PH_IDLE;
      default:          phase_nxt = kaf_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    done = (phase_r == kaf_pkg::PH_SAT);
    if (neg_r) begin
      result = big ? WMIN : -$signed(mag);
    end else begin
      result = big ? WMAX : $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= kaf_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    case (phase_r)
      kaf_pkg::PH_IDLE: begin
        ma_r   <= ma;
        prod_r <= {{OP_BITS{1'b0}}, mb};
        neg_r  <= op_a[OP_BITS-1] ^ op_b[OP_BITS-1];
        frac_r <= frac_shift;
        cnt_r  <= '0;
      end
      kaf_pkg::PH_RUN: begin
        prod_r <= prod_r[0] ? {sum, prod_r[OP_BITS-1:1]}
                            : {1'b0, prod_r[PW-1:1]};
        cnt_r  <= cnt_r + CW'(1);
      end
      kaf_pkg::PH_RND: begin
        rnd_r <= frac_r ? ((wide + HALF_F) >> FRAC_BITS) : ((wide + HALF_Q) >> 32);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/kaf_div.sv]
// ----------------------------------------------------------------------------
// kaf_div
// restoring bit-serial gain divider, (num << frac) / den, saturating
// ----------------------------------------------------------------------------
`default_nettype none

module kaf_div #(
  parameter int WORD_BITS = kaf_pkg::KAF_WORD_BITS,
  parameter int FRAC_BITS = kaf_pkg::KAF_FRAC_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [WORD_BITS-1:0]  num,
  input  wire logic signed [WORD_BITS-1:0]  den,
  output logic                              done,
  output logic signed [WORD_BITS-1:0]       result
);

  localparam int DW = WORD_BITS + FRAC_BITS;
  localparam int CW = $clog2(DW);
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  kaf_pkg::kaf_phase_t phase_r, phase_nxt;
  logic [CW-1:0]        cnt_r;
  logic [DW-1:0]        dq_r;
  logic [WORD_BITS-1:0] rem_r;
  logic [WORD_BITS-1:0] d_r;
  logic                 neg_r;

  logic [WORD_BITS-1:0] mn;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic                 ge;
  logic                 big;
  logic [WORD_BITS-1:0] mag;

  assign mn    = num[WORD_BITS-1] ? WORD_BITS'(-num) : WORD_BITS'(num);
  assign trial = {rem_r, dq_r[DW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = (trial >= {1'b0, d_r});
  assign big   = |dq_r[DW-1:WORD_BITS-1];
  assign mag   = dq_r[WORD_BITS-1:0];

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      kaf_pkg::PH_IDLE: if (start) phase_nxt = kaf_pkg::PH_RUN;
      kaf_pkg::PH_RUN:  if (cnt_r == CW'(DW - 1)) phase_nxt = kaf_pkg::PH_SAT;
      kaf_pkg::PH_SAT:  phase_nxt = kaf_pkg::PH_IDLE;
      default:          phase_nxt = kaf_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    done = (phase_r == kaf_pkg::PH_SAT);
    if (neg_r) begin
      result = big ? WMIN : -$signed(mag);
    end else begin
      result = big ? WMAX : $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= kaf_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    case (phase_r)
      kaf_pkg::PH_IDLE: begin
        dq_r  <= {mn, {FRAC_BITS{1'b0}}};
        rem_r <= '0;
        d_r   <= WORD_BITS'(den);
        neg_r <= num[WORD_BITS-1];
        cnt_r <= '0;
      end
      kaf_pkg::PH_RUN: begin
        rem_r <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
        dq_r  <= {dq_r[DW-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/angle_kalman_filter_unit.sv]
// ----------------------------------------------------------------------------
// angle_kalman_filter_unit
// two-state (angle, gyro bias) kalman filter with serial multiply and divide
// ----------------------------------------------------------------------------
// update: 10 multiplies and 2 divides in sequence, from the accepting edge to the edge
//   that loads the result register
// input: a new word is taken only in the idle step, once the result register is loaded;
//   the shared bit-serial multiplier and the bit-serial divider do every operation, and
//   a stalled result holds the sequencer in its output step and so the input
// reset: synchronous active-low, restores noise registers and estimator state
`default_nettype none

module angle_kalman_filter_unit #(
  parameter int WORD_BITS = kaf_pkg::KAF_WORD_BITS,
  parameter int FRAC_BITS = kaf_pkg::KAF_FRAC_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  // input word
  input  wire logic                                      in_valid,
  output logic                                           in_stall,
  input  wire logic signed [kaf_pkg::FIELD_BITS-1:0]     in_measured_angle,
  input  wire logic signed [kaf_pkg::FIELD_BITS-1:0]     in_measured_rate,
  input  wire logic        [kaf_pkg::NOISE_BITS-1:0]     in_time_step,
  input  wire logic                                      in_restart,
  // result word
  output logic                                           out_valid,
  input  wire logic                                      out_stall,
  output logic signed [kaf_pkg::FIELD_BITS-1:0]          out_best_angle,
  output logic signed [kaf_pkg::FIELD_BITS-1:0]          out_best_rate,
  output logic signed [kaf_pkg::FIELD_BITS-1:0]          out_bias_estimate,
  output logic                                           out_gain_fault,
  // configuration
  input  wire logic                                      cfg_we,
  input  wire logic        [kaf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic        [kaf_pkg::NOISE_BITS-1:0]     cfg_data
);

  localparam int W  = WORD_BITS;
  localparam int FB = kaf_pkg::FIELD_BITS;
  // multiplier operand also holds the unsigned 32-bit time step
  localparam int OP_BITS = (W > 33) ? W : 33;
  // common width for clamping between the word and the 48-bit fields
  localparam int XW = (W > FB) ? W : FB;

  localparam logic signed [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  ZERO_W = '0;
  localparam logic signed [W-1:0]  ONE_W  = (FRAC_BITS >= W - 1) ? WMAX
                                            : (W'(1) << FRAC_BITS);
  localparam logic signed [XW-1:0] WMAX_X = XW'(WMAX);
  localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;
  localparam logic signed [XW-1:0] FMAX_X = XW'({1'b0, {(FB-1){1'b1}}});
  localparam logic signed [XW-1:0] FMIN_X = ~FMAX_X;

  // saturating word arithmetic
  function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] a,
                                                  logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return $signed(s[W-1:0]);
  endfunction

  function automatic logic signed [W-1:0] sat_sub(logic signed [W-1:0] a,
                                                  logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return $signed(s[W-1:0]);
  endfunction

  // unsigned q0.32 noise register into the word format, rounded
  function automatic logic signed [W-1:0] q32_word(logic [kaf_pkg::NOISE_BITS-1:0] v);
    logic [FRAC_BITS+32:0] full;
    logic [FRAC_BITS:0]    s;
    full = {1'b0, v, {FRAC_BITS{1'b0}}} + (FRAC_BITS+33)'(32'h8000_0000);
    s    = full[FRAC_BITS+32:32];
    if ((s >> (W - 1)) != '0) return WMAX;
    return $signed(W'(s));
  endfunction

  function automatic logic signed [W-1:0] field_in(logic signed [FB-1:0] v);
    logic signed [XW-1:0] x;
    x = XW'(v);
    if (x > WMAX_X) return WMAX;
    if (x < WMIN_X) return WMIN;
    return $signed(W'(x));
  endfunction

  function automatic logic signed [FB-1:0] field_out(logic signed [W-1:0] v);
    logic signed [XW-1:0] x;
    x = XW'(v);
    if (x > FMAX_X) return $signed(FB'(FMAX_X));
    if (x < FMIN_X) return $signed(FB'(FMIN_X));
    return $signed(FB'(x));
  endfunction

  // sequencer
  kaf_pkg::kaf_state_t state_r, state_nxt;
  logic issued_r;

  // noise registers
  logic [kaf_pkg::NOISE_BITS-1:0] angle_noise_r;
  logic [kaf_pkg::NOISE_BITS-1:0] bias_noise_r;
  logic [kaf_pkg::NOISE_BITS-1:0] meas_noise_r;

  // estimator state
  logic signed [W-1:0] ang_r, bias_r, aa_r, ab_r, ba_r, bb_r;

  // working registers of one update
  logic signed [W-1:0] meas_r, rate_r;
  logic [kaf_pkg::NOISE_BITS-1:0] dt_r;
  logic signed [W-1:0] tmp_r, err_r, e_r, p0_r, t1_r, k0_r, k1_r;
  logic                fault_r;

  // result register
  logic                 out_valid_r;
  logic signed [FB-1:0] out_angle_r, out_rate_r, out_bias_r;
  logic                 out_fault_r;

  // unit hookup
  logic                      mul_start, div_start;
  logic                      mul_done, div_done, unit_done;
  logic signed [OP_BITS-1:0] mul_a, mul_b;
  logic                      mul_frac;
  logic signed [W-1:0]       mul_res, div_res;
  logic signed [W-1:0]       div_num;
  logic                      in_acc, out_free, unit_step, div_step, gain_bad;
  logic signed [W-1:0]       qa_w, qg_w, mn_w;
  logic signed [OP_BITS-1:0] dt_op;

  assign qa_w = q32_word(angle_noise_r);
  assign qg_w = q32_word(bias_noise_r);
  assign mn_w = q32_word(meas_noise_r);
  assign dt_op = $signed(OP_BITS'({1'b0, dt_r}));

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign unit_done = mul_done || div_done;
  // innovation denominator not positive
  assign gain_bad  = e_r[W-1] || (e_r == ZERO_W);

  // next step
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kaf_pkg::ST_IDLE:    if (in_acc) state_nxt = kaf_pkg::ST_M_ANG;
      kaf_pkg::ST_M_ANG:   if (unit_done) state_nxt = kaf_pkg::ST_M_AA;
      kaf_pkg::ST_M_AA:    if (unit_done) state_nxt = kaf_pkg::ST_M_AB;
      kaf_pkg::ST_M_AB:    if (unit_done) state_nxt = kaf_pkg::ST_M_BB;
      kaf_pkg::ST_M_BB:    if (unit_done) state_nxt = kaf_pkg::ST_GAIN;
      kaf_pkg::ST_GAIN:    state_nxt = kaf_pkg::ST_D_K0;
      kaf_pkg::ST_D_K0:    if (unit_done) state_nxt = kaf_pkg::ST_D_K1;
      kaf_pkg::ST_D_K1:    if (unit_done) state_nxt = kaf_pkg::ST_M_CAA;
      kaf_pkg::ST_M_CAA:   if (unit_done) state_nxt = kaf_pkg::ST_M_CAB;
      kaf_pkg::ST_M_CAB:   if (unit_done) state_nxt = kaf_pkg::ST_M_CBA;
      kaf_pkg::ST_M_CBA:   if (unit_done) state_nxt = kaf_pkg::ST_M_CBB;
      kaf_pkg::ST_M_CBB:   if (unit_done) state_nxt = kaf_pkg::ST_M_CANG;
      kaf_pkg::ST_M_CANG:  if (unit_done) state_nxt = kaf_pkg::ST_M_CBIAS;
      kaf_pkg::ST_M_CBIAS: if (unit_done) state_nxt = kaf_pkg::ST_OUT;
      kaf_pkg::ST_OUT:     if (out_free) state_nxt = kaf_pkg::ST_IDLE;
      default:             state_nxt = kaf_pkg::ST_IDLE;
    endcase
  end

  // step outputs: unit starts and operand selection
  always_comb begin
    in_stall  = (state_r != kaf_pkg::ST_IDLE);
    unit_step = 1'b1;
    div_step  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_frac  = 1'b0;
    div_num   = aa_r;
    case (state_r)
      kaf_pkg::ST_M_ANG: begin
        mul_a = OP_BITS'(sat_sub(rate_r, bias_r));
        mul_b = dt_op;
      end
      kaf_pkg::ST_M_AA: begin
        mul_a = OP_BITS'(tmp_r);
        mul_b = dt_op;
      end
      kaf_pkg::ST_M_AB: begin
        mul_a = OP_BITS'(sat_sub(ZERO_W, bb_r));
        mul_b = dt_op;
      end
      kaf_pkg::ST_M_BB: begin
        mul_a = OP_BITS'(qg_w);
        mul_b = dt_op;
      end
      kaf_pkg::ST_D_K0: begin
        div_step = 1'b1;
        div_num  = aa_r;
      end
      kaf_pkg::ST_D_K1: begin
        div_step = 1'b1;
        div_num  = ba_r;
      end
      kaf_pkg::ST_M_CAA: begin
        mul_a = OP_BITS'(k0_r);  mul_b = OP_BITS'(p0_r);  mul_frac = 1'b1;
      end
      kaf_pkg::ST_M_CAB: begin
        mul_a = OP_BITS'(k0_r);  mul_b = OP_BITS'(t1_r);  mul_frac = 1'b1;
      end
      kaf_pkg::ST_M_CBA: begin
        mul_a = OP_BITS'(k1_r);  mul_b = OP_BITS'(p0_r);  mul_frac = 1'b1;
      end
      kaf_pkg::ST_M_CBB: begin
        mul_a = OP_BITS'(k1_r);  mul_b = OP_BITS'(t1_r);  mul_frac = 1'b1;
      end
      kaf_pkg::ST_M_CANG: begin
        mul_a = OP_BITS'(k0_r);  mul_b = OP_BITS'(err_r); mul_frac = 1'b1;
      end
      kaf_pkg::ST_M_CBIAS: begin
        mul_a = OP_BITS'(k1_r);  mul_b = OP_BITS'(err_r); mul_frac = 1'b1;
      end
      default: unit_step = 1'b0;
    endcase
    mul_start = unit_step && !div_step && !issued_r;
    div_start = div_step && !issued_r;
  end

  kaf_mul #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .OP_BITS   (OP_BITS)
  ) u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mul_start),
    .op_a       (mul_a),
    .op_b       (mul_b),
    .frac_shift (mul_frac),
    .done       (mul_done),
    .result     (mul_res)
  );

  kaf_div #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (e_r),
    .done   (div_done),
    .result (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= kaf_pkg::ST_IDLE;
      issued_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      angle_noise_r <= kaf_pkg::ANGLE_NOISE_RST;
      bias_noise_r  <= kaf_pkg::BIAS_NOISE_RST;
      meas_noise_r  <= kaf_pkg::MEAS_NOISE_RST;
      ang_r         <= ZERO_W;
      bias_r        <= ZERO_W;
      aa_r          <= ONE_W;
      ab_r          <= ZERO_W;
      ba_r          <= ZERO_W;
      bb_r          <= ONE_W;
    end else begin
      state_r <= state_nxt;

      // one start per step, cleared when the unit hands back its result
      if (unit_done) begin
        issued_r <= 1'b0;
      end else if (mul_start || div_start) begin
        issued_r <= 1'b1;
      end

      // config writes, unknown index ignored
      if (cfg_we) begin
        case (cfg_index)
          kaf_pkg::REG_ANGLE_NOISE: angle_noise_r <= cfg_data;
          kaf_pkg::REG_BIAS_NOISE:  bias_noise_r  <= cfg_data;
          kaf_pkg::REG_MEAS_NOISE:  meas_noise_r  <= cfg_data;
          default: begin
          end
        endcase
      end

      // take a word, restart clears the estimator before the update
      if (in_acc) begin
        meas_r <= field_in(in_measured_angle);
        rate_r <= field_in(in_measured_rate);
        dt_r   <= in_time_step;
        if (in_restart) begin
          ang_r  <= ZERO_W;
          bias_r <= ZERO_W;
          aa_r   <= ONE_W;
          ab_r   <= ZERO_W;
          ba_r   <= ZERO_W;
          bb_r   <= ONE_W;
        end
      end

      case (state_r)
        // predict: angle += (rate - bias) * dt, and build qa - ab - ba on the side
        kaf_pkg::ST_M_ANG: begin
          if (mul_start) tmp_r <= sat_sub(qa_w, ab_r);
          if (mul_done) begin
            ang_r <= sat_add(ang_r, mul_res);
            tmp_r <= sat_sub(tmp_r, ba_r);
          end
        end
        kaf_pkg::ST_M_AA: if (mul_done) aa_r <= sat_add(aa_r, mul_res);
        kaf_pkg::ST_M_AB: begin
          if (mul_done) begin
            ab_r <= sat_add(ab_r, mul_res);
            ba_r <= sat_add(ba_r, mul_res);
          end
        end
        kaf_pkg::ST_M_BB: if (mul_done) bb_r <= sat_add(bb_r, mul_res);
        // innovation and denominator, keep predicted aa and ab for the correction
        kaf_pkg::ST_GAIN: begin
          err_r <= sat_sub(meas_r, ang_r);
          e_r   <= sat_add(mn_w, aa_r);
          p0_r  <= aa_r;
          t1_r  <= ab_r;
        end
        // gains are zero on a bad denominator, so the correction changes nothing
        kaf_pkg::ST_D_K0: begin
          if (div_done) begin
            k0_r    <= gain_bad ? ZERO_W : div_res;
            fault_r <= gain_bad;
          end
        end
        kaf_pkg::ST_D_K1:    if (div_done) k1_r <= fault_r ? ZERO_W : div_res;
        kaf_pkg::ST_M_CAA:   if (mul_done) aa_r <= sat_sub(aa_r, mul_res);
        kaf_pkg::ST_M_CAB:   if (mul_done) ab_r <= sat_sub(ab_r, mul_res);
        kaf_pkg::ST_M_CBA:   if (mul_done) ba_r <= sat_sub(ba_r, mul_res);
        kaf_pkg::ST_M_CBB:   if (mul_done) bb_r <= sat_sub(bb_r, mul_res);
        kaf_pkg::ST_M_CANG:  if (mul_done) ang_r <= sat_add(ang_r, mul_res);
        kaf_pkg::ST_M_CBIAS: if (mul_done) bias_r <= sat_add(bias_r, mul_res);
        default: begin
        end
      endcase

      // result register, parts the sequencer from the output side
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == kaf_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
        out_angle_r <= field_out(ang_r);
        out_rate_r  <= field_out(sat_sub(rate_r, bias_r));
        out_bias_r  <= field_out(bias_r);
        out_fault_r <= fault_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_best_angle    = out_angle_r;
  assign out_best_rate     = out_rate_r;
  assign out_bias_estimate = out_bias_r;
  assign out_gain_fault    = out_fault_r;

  // a result word only comes out of the final step
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == kaf_pkg::ST_OUT))
    else $error("result word appeared outside the output step");

  // a flagged denominator leaves both gains at zero
  a_fault_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kaf_pkg::ST_OUT && fault_r) |-> (k0_r == ZERO_W && k1_r == ZERO_W))
    else $error("gain not zero on denominator fault");

  // an accepted word starts the predict step next
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == kaf_pkg::ST_M_ANG))
    else $error("accepted word did not start an update");

  // the two serial units never finish together
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && div_done))
    else $error("multiplier and divider finished in the same cycle");

endmodule

`default_nettype wire
